@@ hw/rtl/dtsi_pkg.sv @@
package dtsi_pkg;

    localparam int unsigned VALUE_W   = 32;
    localparam int unsigned FACTOR_W  = 16;
    localparam int unsigned CHAR_W    = 8;
    localparam int unsigned DIGIT_W   = 4;
    localparam int unsigned RUN_CNT_W = 4;
    localparam int unsigned FRAC_KEEP = 4;
    localparam int unsigned FCNT_W    = 3;
    localparam int unsigned KEEP_W    = 3;
    localparam int unsigned FRAC_W    = 14;

    localparam logic [CHAR_W-1:0] CHAR_DOT  = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;

    localparam logic [FRAC_W-1:0] POW10 [5] = '{14'd1, 14'd10, 14'd100, 14'd1000, 14'd10000};

    typedef logic [FRAC_KEEP-1:0][DIGIT_W-1:0] frac_dig_t;

    // One finished text handed from the parser to the scaler.
    typedef struct packed {
        logic               valid;
        logic               dot_found;
        logic [VALUE_W-1:0] base;
        frac_dig_t          frac_dig;
    } fin_t;

    // Fraction digits kept: decimal digit count of the factor minus one.
    function automatic logic [KEEP_W-1:0] keep_digits(input logic [FACTOR_W-1:0] f);
        logic [KEEP_W-1:0] k;
        if (f >= 16'd10000)
            k = 3'd4;
        else if (f >= 16'd1000)
            k = 3'd3;
        else if (f >= 16'd100)
            k = 3'd2;
        else if (f >= 16'd10)
            k = 3'd1;
        else
            k = 3'd0;
        return k;
    endfunction

    // Places the first fraction digits at their weights; digits never read are zero,
    // which gives the zero padding, and digits past the kept count drop out.
    function automatic logic [FRAC_W-1:0] frac_sum(input frac_dig_t dig,
                                                   input logic [KEEP_W-1:0] keep);
        logic [FRAC_W-1:0] sum;
        logic [KEEP_W-1:0] place;
        sum = '0;
        for (int i = 0; i < FRAC_KEEP; i++)
        begin
            place = keep - KEEP_W'(i) - KEEP_W'(1);
            if (KEEP_W'(i) < keep)
                sum = sum + FRAC_W'(FRAC_W'(dig[i]) * POW10[place]);
        end
        return sum;
    endfunction

endpackage

@@ hw/rtl/dtsi_if.sv @@
interface dtsi_in_if;
    import dtsi_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] ch;
    logic              last;

    modport source (output valid, output ch, output last, input ready);
    modport sink (input valid, input ch, input last, output ready);
endinterface

interface dtsi_out_if;
    import dtsi_pkg::*;

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink (input valid, input value, output ready);
endinterface

@@ hw/rtl/dtsi_parse.sv @@
module dtsi_parse #(
    parameter int unsigned MAX_CHARS      = 64,
    parameter int unsigned MAX_INT_DIGITS = 10
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        advance,
    input  logic                        in_valid,
    input  logic [dtsi_pkg::CHAR_W-1:0] ch,
    input  logic                        last,
    output dtsi_pkg::fin_t              fin
);
    import dtsi_pkg::*;

    localparam int unsigned POS_W = $clog2(MAX_CHARS + 1);

    logic [POS_W-1:0]     char_pos_reg, char_pos_next;
    logic [VALUE_W-1:0]   run_value_reg, run_value_next;
    logic                 prev_digit_reg, prev_digit_next;
    logic                 dot_pending_reg, dot_pending_next;
    logic                 in_frac_reg, in_frac_next;
    logic                 dot_found_reg, dot_found_next;
    logic [VALUE_W-1:0]   int_at_dot_reg, int_at_dot_next;
    frac_dig_t            frac_dig_reg, frac_dig_next;
    logic [FCNT_W-1:0]    frac_cnt_reg, frac_cnt_next;
    logic [VALUE_W-1:0]   first_val_reg, first_val_next;
    logic [RUN_CNT_W-1:0] first_cnt_reg, first_cnt_next;
    logic                 first_done_reg, first_done_next;
    fin_t                 fin_reg, fin_next;

    logic                 is_digit;
    logic [DIGIT_W-1:0]   digit;
    logic [CHAR_W-1:0]    ch_off;

    assign is_digit = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
    assign ch_off   = ch - CHAR_ZERO;
    assign digit    = is_digit ? ch_off[DIGIT_W-1:0] : '0;

    always_comb
    begin
        char_pos_next    = char_pos_reg;
        run_value_next   = run_value_reg;
        prev_digit_next  = prev_digit_reg;
        dot_pending_next = dot_pending_reg;
        in_frac_next     = in_frac_reg;
        dot_found_next   = dot_found_reg;
        int_at_dot_next  = int_at_dot_reg;
        frac_dig_next    = frac_dig_reg;
        frac_cnt_next    = frac_cnt_reg;
        first_val_next   = first_val_reg;
        first_cnt_next   = first_cnt_reg;
        first_done_next  = first_done_reg;
        fin_next         = fin_reg;
        fin_next.valid   = 1'b0;

        if (in_valid && (char_pos_reg < POS_W'(MAX_CHARS)))
        begin
            char_pos_next = char_pos_reg + POS_W'(1);

            // A dot is taken only when a digit follows it.
            if (dot_pending_reg)
            begin
                if (is_digit && !dot_found_reg)
                begin
                    dot_found_next = 1'b1;
                    in_frac_next   = 1'b1;
                end
                dot_pending_next = 1'b0;
            end

            if (in_frac_next)
            begin
                if (is_digit)
                begin
                    if (frac_cnt_reg < FCNT_W'(FRAC_KEEP))
                    begin
                        frac_dig_next[frac_cnt_reg[FCNT_W-2:0]] = digit;
                        frac_cnt_next = frac_cnt_reg + FCNT_W'(1);
                    end
                end
                else
                begin
                    in_frac_next = 1'b0;
                end
            end

            if (!first_done_reg)
            begin
                if (is_digit)
                begin
                    if (first_cnt_reg < RUN_CNT_W'(MAX_INT_DIGITS))
                    begin
                        first_val_next = (first_val_reg << 3) + (first_val_reg << 1)
                                         + VALUE_W'(digit);
                        first_cnt_next = first_cnt_reg + RUN_CNT_W'(1);
                    end
                    if (first_cnt_next >= RUN_CNT_W'(MAX_INT_DIGITS))
                        first_done_next = 1'b1;
                end
                else if (first_cnt_reg != '0)
                begin
                    first_done_next = 1'b1;
                end
            end

            if ((ch == CHAR_DOT) && prev_digit_reg && !dot_found_next)
            begin
                int_at_dot_next  = run_value_reg;
                dot_pending_next = 1'b1;
            end

            if (is_digit)
                run_value_next = prev_digit_reg
                    ? (run_value_reg << 3) + (run_value_reg << 1) + VALUE_W'(digit)
                    : VALUE_W'(digit);
            else
                run_value_next = '0;
            prev_digit_next = is_digit;
        end

        if (in_valid && last)
        begin
            fin_next.valid     = 1'b1;
            fin_next.dot_found = dot_found_next;
            fin_next.base      = dot_found_next ? int_at_dot_next : first_val_next;
            fin_next.frac_dig  = frac_dig_next;

            char_pos_next    = '0;
            run_value_next   = '0;
            prev_digit_next  = 1'b0;
            dot_pending_next = 1'b0;
            in_frac_next     = 1'b0;
            dot_found_next   = 1'b0;
            int_at_dot_next  = '0;
            frac_dig_next    = '0;
            frac_cnt_next    = '0;
            first_val_next   = '0;
            first_cnt_next   = '0;
            first_done_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_pos_reg    <= '0;
            run_value_reg   <= '0;
            prev_digit_reg  <= 1'b0;
            dot_pending_reg <= 1'b0;
            in_frac_reg     <= 1'b0;
            dot_found_reg   <= 1'b0;
            int_at_dot_reg  <= '0;
            frac_dig_reg    <= '0;
            frac_cnt_reg    <= '0;
            first_val_reg   <= '0;
            first_cnt_reg   <= '0;
            first_done_reg  <= 1'b0;
            fin_reg         <= '0;
        end
        else if (advance)
        begin
            char_pos_reg    <= char_pos_next;
            run_value_reg   <= run_value_next;
            prev_digit_reg  <= prev_digit_next;
            dot_pending_reg <= dot_pending_next;
            in_frac_reg     <= in_frac_next;
            dot_found_reg   <= dot_found_next;
            int_at_dot_reg  <= int_at_dot_next;
            frac_dig_reg    <= frac_dig_next;
            frac_cnt_reg    <= frac_cnt_next;
            first_val_reg   <= first_val_next;
            first_cnt_reg   <= first_cnt_next;
            first_done_reg  <= first_done_next;
            fin_reg         <= fin_next;
        end
    end

    assign fin = fin_reg;

endmodule

@@ hw/rtl/dtsi_scale.sv @@
module dtsi_scale (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  dtsi_pkg::fin_t                fin,
    input  logic [dtsi_pkg::FACTOR_W-1:0] factor,
    output logic                          out_valid,
    output logic [dtsi_pkg::VALUE_W-1:0]  value
);
    import dtsi_pkg::*;

    logic                        mul_valid_reg;
    logic [VALUE_W-1:0]          prod_reg, prod_next;
    logic [FRAC_W-1:0]           frac_reg, frac_next;
    logic                        out_valid_reg;
    logic [VALUE_W-1:0]          value_reg, value_next;
    logic [VALUE_W+FACTOR_W-1:0] prod_full;

    assign prod_full  = fin.base * factor;
    assign prod_next  = prod_full[VALUE_W-1:0];
    assign frac_next  = fin.dot_found ? frac_sum(fin.frac_dig, keep_digits(factor)) : '0;
    assign value_next = prod_reg + VALUE_W'(frac_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            mul_valid_reg <= fin.valid;
            out_valid_reg <= mul_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prod_reg  <= prod_next;
            frac_reg  <= frac_next;
            value_reg <= value_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;

endmodule

@@ hw/rtl/decimal_text_to_scaled_int.sv @@
// Channel   Direction  Payload              Transfer
// chars     in         ch[7:0], last        valid && ready
// result    out        value[31:0]          valid && ready
// cfg       in         cfg_wdata[15:0]      cfg_we (factor register)
//
// One character is taken every cycle while no result waits untaken. The input register
// loads at the transfer edge, and the text's result then passes the parse, multiply and
// result registers before it is valid.
// Reset clears all text state and sets the factor to one; there is no clearing pass.
// The whole pipeline holds while a result waits untaken, so chars.ready drops only then.
module decimal_text_to_scaled_int #(
    parameter int unsigned MAX_CHARS      = 64,
    parameter int unsigned MAX_INT_DIGITS = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    dtsi_in_if.sink                       chars,
    dtsi_out_if.source                    result,
    input  logic                          cfg_we,
    input  logic [dtsi_pkg::FACTOR_W-1:0] cfg_wdata
);
    import dtsi_pkg::*;

    logic                advance;
    logic                in_valid_reg;
    logic [CHAR_W-1:0]   ch_reg;
    logic                last_reg;
    logic [FACTOR_W-1:0] factor_reg;
    fin_t                fin;
    logic                out_valid;
    logic [VALUE_W-1:0]  value;

    assign advance     = !(out_valid && !result.ready);
    assign chars.ready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            factor_reg <= FACTOR_W'(1);
        else if (cfg_we)
            factor_reg <= cfg_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (advance)
            in_valid_reg <= chars.valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ch_reg   <= chars.ch;
            last_reg <= chars.last;
        end
    end

    dtsi_parse #(
        .MAX_CHARS      (MAX_CHARS),
        .MAX_INT_DIGITS (MAX_INT_DIGITS)
    ) u_parse (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .in_valid (in_valid_reg),
        .ch       (ch_reg),
        .last     (last_reg),
        .fin      (fin)
    );

    dtsi_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .fin       (fin),
        .factor    (factor_reg),
        .out_valid (out_valid),
        .value     (value)
    );

    assign result.valid = out_valid;
    assign result.value = value;

endmodule

@@ hw/rtl/dtsi_checker.sv @@
module dtsi_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        in_last,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] out_value
);

    // A waiting result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before its transfer");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_value))
        else $error("result value changed while stalled");

    // Input is refused only while a result waits untaken.
    a_ready_only_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input refused without an output stall");

    // A last character whose text then passes the parse, multiply and result registers without a stall yields a result.
    a_last_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_last ##1 in_ready ##1 in_ready ##1 in_ready
        |=> out_valid)
        else $error("no result after the last character");

endmodule

bind decimal_text_to_scaled_int dtsi_checker u_dtsi_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (chars.valid),
    .in_ready  (chars.ready),
    .in_last   (chars.last),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_value (result.value)
);
